[hw/rtl/pala_pkg.sv]
// Package for the polyline arc-length interpolator.
// Holds opcodes, status codes, register indexes and the request types of the
// shared divider and square-root units. No dependencies.
package pala_pkg;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;
   localparam int SQRT_W    = 64;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_DIST   = 2'd1;
   localparam logic [1:0] OP_CURSOR = 2'd2;

   localparam logic [2:0] ST_INTERP      = 3'd0;
   localparam logic [2:0] ST_CLAMP_START = 3'd1;
   localparam logic [2:0] ST_CLAMP_END   = 3'd2;
   localparam logic [2:0] ST_STORED      = 3'd3;
   localparam logic [2:0] ST_ZERO_SEG    = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd5;

   localparam logic CSR_TOTAL_LENGTH = 1'b0;
   localparam logic CSR_POINT_COUNT  = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic                 rem_nonzero;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [SQRT_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

endpackage

[hw/rtl/pala_mem.sv]
// Point table: x, y and cumulative length for each polyline entry.
// One write port and one registered read port. Depends on nothing.
module pala_mem #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  logic [31:0]                   wr_x,
   input  logic [31:0]                   wr_y,
   input  logic [31:0]                   wr_cum,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output logic [31:0]                   rd_x,
   output logic [31:0]                   rd_y,
   output logic [31:0]                   rd_cum
);
   logic [31:0] x_mem   [MAX_POINTS];
   logic [31:0] y_mem   [MAX_POINTS];
   logic [31:0] cum_mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr]   <= wr_x;
         y_mem[wr_addr]   <= wr_y;
         cum_mem[wr_addr] <= wr_cum;
      end
   end

   always_ff @(posedge clock) begin
      rd_x   <= x_mem[rd_addr];
      rd_y   <= y_mem[rd_addr];
      rd_cum <= cum_mem[rd_addr];
   end
endmodule

[hw/rtl/pala_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Uses the request and response types of pala_pkg.
module pala_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pala_pkg::div_req_type req,
   output pala_pkg::div_rsp_type rsp
);
   import pala_pkg::*;

   logic                 busy_ff;
   logic [5:0]           count_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            quo_ff   <= req.dividend;
            rem_ff   <= '0;
            den_ff   <= req.divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
            if (count_ff == 6'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff + 6'd1;
         end
      end
   end

   assign rsp.done        = done_ff;
   assign rsp.quotient    = quo_ff;
   assign rsp.rem_nonzero = rem_ff != '0;
endmodule

[hw/rtl/pala_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
// Uses the request and response types of pala_pkg.
module pala_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  pala_pkg::sqrt_req_type req,
   output pala_pkg::sqrt_rsp_type rsp
);
   import pala_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [4:0]        count_ff;
   logic [SQRT_W-1:0] v_ff;
   logic [SQRT_W-1:0] r_ff;
   logic [SQRT_W-1:0] bit_ff;
   logic [SQRT_W-1:0] trial;

   assign trial = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            v_ff     <= req.radicand;
            r_ff     <= '0;
            bit_ff   <= SQRT_W'(1) << (SQRT_W - 2);
         end else if (busy_ff) begin
            if (v_ff >= trial) begin
               v_ff <= v_ff - trial;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff + 5'd1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = r_ff[31:0];
endmodule

[hw/rtl/polyline_arc_length_lerp.sv]
// Top level of the polyline arc-length interpolator: sequencer, shared multiplier,
// point table, divider and square-root units.
// Depends on pala_pkg, pala_mem, pala_div and pala_sqrt.
//
//   Channel  Direction  Handshake           Carries
//   req_     in         valid / stall       load entry or distance / cursor query
//   rsp_     out        valid / stall       position, direction and status
//   csr_     in         valid / ready       register index and write data
//
// A load answers in the cycle after acceptance; no further request is accepted
// until that response has been taken. A query runs a linear search through the
// table's one read port, then a divide for the fraction, a square root and two
// divides for the direction.
// Reset is synchronous and clears only control state; the table is undefined
// until loaded. One request is in flight at a time: req_stall stays high from
// acceptance until the response has been taken.
module polyline_arc_length_lerp #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_entry_index,
   input  logic [31:0] req_load_x,
   input  logic [31:0] req_load_y,
   input  logic [31:0] req_load_cum_length,
   input  logic [31:0] req_query_distance,
   input  logic [16:0] req_query_cursor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [15:0] rsp_dir_x,
   output logic [15:0] rsp_dir_y,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import pala_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int CW = (NW > 7) ? NW : 7;

   typedef enum logic [4:0] {
      S_IDLE, S_CUR_MUL, S_CHECK, S_SRCH_RD, S_SRCH_CMP, S_A_RD, S_A_GOT,
      S_B_RD, S_B_GOT, S_PCT_DIV, S_X_MUL, S_X_ADD, S_Y_MUL, S_Y_ADD, S_NORM,
      S_UX_MUL, S_UY_MUL, S_SQRT_GO, S_SQRT, S_UX_DIV, S_UY_DIV, S_PT_RD,
      S_PT_GOT, S_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [31:0] total_length_ff;
   logic [6:0]  point_count_ff;

   // Request and working registers.
   logic [NW-1:0]      n_ff;
   logic [NW-1:0]      k_ff;
   logic [AW-1:0]      addr_ff;
   logic [16:0]        cursor_ff;
   logic signed [32:0] d_ff;
   logic [2:0]         stat_ff;
   logic [31:0]        x0_ff;
   logic [31:0]        y0_ff;
   logic [31:0]        c0_ff;
   logic signed [32:0] ddx_ff;
   logic signed [32:0] ddy_ff;
   logic [31:0]        ux_ff;
   logic [31:0]        uy_ff;
   logic               neg_ff;
   logic signed [30:0] pct_ff;
   logic signed [67:0] prod_ff;
   logic [61:0]        sq_ff;
   logic [61:0]        sum_ff;
   logic [31:0]        len_ff;

   logic        rsp_valid_ff;
   logic [31:0] pos_x_ff;
   logic [31:0] pos_y_ff;
   logic [15:0] dir_x_ff;
   logic [15:0] dir_y_ff;
   logic [2:0]  status_ff;

   div_req_type  div_req_ff;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req_ff;
   sqrt_rsp_type sqrt_rsp;

   logic [31:0] rd_x;
   logic [31:0] rd_y;
   logic [31:0] rd_cum;

   logic        req_accept;
   logic [15:0] idx_wide;
   logic        mem_we;
   logic [CW-1:0] pc_wide;
   logic [NW-1:0] n_clamped;

   logic signed [33:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [67:0] prod;

   logic signed [33:0] num_b;
   logic signed [33:0] den_b;
   logic [32:0]        num_abs;
   logic [32:0]        den_abs;
   logic [48:0]        pct_mag;
   logic signed [52:0] pos_sum;
   logic [31:0]        pos_sat;
   logic [31:0]        mx;
   logic [15:0]        unit_mag;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != S_IDLE;
   assign csr_ready  = 1'b1;

   // Load requests whose index lies beyond the table still answer, but write nothing.
   assign idx_wide = 16'(req_entry_index);
   assign mem_we   = req_accept && req_opcode == OP_LOAD && idx_wide < 16'(MAX_POINTS);

   // The point count in use is held to the range the table supports.
   assign pc_wide = CW'(point_count_ff);
   always_comb begin
      if (pc_wide < CW'(2)) begin
         n_clamped = NW'(2);
      end else if (pc_wide > CW'(MAX_POINTS)) begin
         n_clamped = NW'(MAX_POINTS);
      end else begin
         n_clamped = pc_wide[NW-1:0];
      end
   end

   pala_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_x    (req_load_x),
      .wr_y    (req_load_y),
      .wr_cum  (req_load_cum_length),
      .rd_addr (addr_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y),
      .rd_cum  (rd_cum)
   );

   pala_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   pala_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req_ff),
      .rsp   (sqrt_rsp)
   );

   // One shared multiplier; its operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         S_CUR_MUL: begin
            mul_a = $signed({2'b0, total_length_ff});
            mul_b = $signed({17'b0, cursor_ff});
         end
         S_X_MUL: begin
            mul_a = 34'(ddx_ff);
            mul_b = 34'(pct_ff);
         end
         S_Y_MUL: begin
            mul_a = 34'(ddy_ff);
            mul_b = 34'(pct_ff);
         end
         S_UX_MUL: begin
            mul_a = $signed({2'b0, ux_ff});
            mul_b = $signed({2'b0, ux_ff});
         end
         S_UY_MUL: begin
            mul_a = $signed({2'b0, uy_ff});
            mul_b = $signed({2'b0, uy_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   // Segment numerator and denominator once both end points are known.
   assign num_b   = 34'(d_ff) - $signed({2'b0, c0_ff});
   assign den_b   = $signed({2'b0, rd_cum}) - $signed({2'b0, c0_ff});
   assign num_abs = num_b[33] ? 33'(-num_b) : num_b[32:0];
   assign den_abs = den_b[33] ? 33'(-den_b) : den_b[32:0];

   // A negative fraction rounds toward minus infinity.
   assign pct_mag = {1'b0, div_rsp.quotient} + 49'(neg_ff && div_rsp.rem_nonzero);

   // Position: start point plus the floored product, saturated to 32 bits.
   assign pos_sum = 53'($signed(x0_ff)) + 53'($signed(prod_ff[67:16]));
   always_comb begin
      logic signed [52:0] base;
      base = (state_ff == S_Y_ADD) ? 53'($signed(y0_ff)) + 53'($signed(prod_ff[67:16]))
                                   : pos_sum;
      if (base > 53'sd2147483647) begin
         pos_sat = 32'h7fff_ffff;
      end else if (base < -53'sd2147483648) begin
         pos_sat = 32'h8000_0000;
      end else begin
         pos_sat = base[31:0];
      end
   end

   assign mx       = (ux_ff > uy_ff) ? ux_ff : uy_ff;
   assign unit_mag = (div_rsp.quotient > 48'd32767) ? 16'd32767 : div_rsp.quotient[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         total_length_ff   <= '0;
         point_count_ff    <= 7'd2;
         div_req_ff.start  <= 1'b0;
         sqrt_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start  <= 1'b0;
         sqrt_req_ff.start <= 1'b0;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TOTAL_LENGTH: total_length_ff <= csr_wdata;
               CSR_POINT_COUNT:  point_count_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  n_ff <= n_clamped;
                  unique case (req_opcode)
                     OP_LOAD: begin
                        pos_x_ff     <= '0;
                        pos_y_ff     <= '0;
                        dir_x_ff     <= '0;
                        dir_y_ff     <= '0;
                        status_ff    <= ST_STORED;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_OUT;
                     end
                     OP_DIST: begin
                        d_ff     <= 33'($signed(req_query_distance));
                        state_ff <= S_CHECK;
                     end
                     OP_CURSOR: begin
                        cursor_ff <= (req_query_cursor > 17'd65536) ? 17'd65536
                                                                     : req_query_cursor;
                        state_ff  <= S_CUR_MUL;
                     end
                     default: ;  // Unused opcode: no response.
                  endcase
               end
            end
            S_CUR_MUL: begin
               d_ff     <= $signed({1'b0, prod[47:16]});
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (d_ff < 0) begin
                  addr_ff  <= '0;
                  stat_ff  <= ST_CLAMP_START;
                  state_ff <= S_PT_RD;
               end else if (d_ff > $signed({1'b0, total_length_ff})) begin
                  addr_ff  <= AW'(n_ff - NW'(1));
                  stat_ff  <= ST_CLAMP_END;
                  state_ff <= S_PT_RD;
               end else begin
                  k_ff     <= NW'(1);
                  addr_ff  <= AW'(1);
                  state_ff <= S_SRCH_RD;
               end
            end
            S_SRCH_RD: state_ff <= S_SRCH_CMP;
            S_SRCH_CMP: begin
               if ({1'b0, rd_cum} >= d_ff[32:0]) begin
                  addr_ff  <= AW'(k_ff - NW'(1));
                  state_ff <= S_A_RD;
               end else if (k_ff + NW'(1) >= n_ff) begin
                  addr_ff  <= '0;
                  stat_ff  <= ST_NOT_FOUND;
                  state_ff <= S_PT_RD;
               end else begin
                  k_ff     <= k_ff + NW'(1);
                  addr_ff  <= AW'(k_ff + NW'(1));
                  state_ff <= S_SRCH_RD;
               end
            end
            S_A_RD: state_ff <= S_A_GOT;
            S_A_GOT: begin
               x0_ff    <= rd_x;
               y0_ff    <= rd_y;
               c0_ff    <= rd_cum;
               addr_ff  <= k_ff[AW-1:0];
               state_ff <= S_B_RD;
            end
            S_B_RD: state_ff <= S_B_GOT;
            S_B_GOT: begin
               ddx_ff <= 33'($signed(rd_x)) - 33'($signed(x0_ff));
               ddy_ff <= 33'($signed(rd_y)) - 33'($signed(y0_ff));
               if (den_b == 0) begin
                  pos_x_ff     <= x0_ff;
                  pos_y_ff     <= y0_ff;
                  dir_x_ff     <= '0;
                  dir_y_ff     <= '0;
                  status_ff    <= ST_ZERO_SEG;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  neg_ff              <= num_b[33] ^ den_b[33];
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= {num_abs[31:0], 16'b0};
                  div_req_ff.divisor  <= den_abs[31:0];
                  state_ff            <= S_PCT_DIV;
               end
            end
            S_PCT_DIV: begin
               if (div_rsp.done) begin
                  if (pct_mag > 49'h2000_0000) begin
                     pct_ff <= neg_ff ? -31'sh2000_0000 : 31'sh2000_0000;
                  end else begin
                     pct_ff <= neg_ff ? -$signed(pct_mag[30:0]) : $signed(pct_mag[30:0]);
                  end
                  state_ff <= S_X_MUL;
               end
            end
            S_X_MUL: begin
               prod_ff  <= prod;
               state_ff <= S_X_ADD;
            end
            S_X_ADD: begin
               pos_x_ff <= pos_sat;
               state_ff <= S_Y_MUL;
            end
            S_Y_MUL: begin
               prod_ff  <= prod;
               ux_ff    <= ddx_ff[32] ? 32'(-ddx_ff) : ddx_ff[31:0];
               uy_ff    <= ddy_ff[32] ? 32'(-ddy_ff) : ddy_ff[31:0];
               state_ff <= S_Y_ADD;
            end
            S_Y_ADD: begin
               pos_y_ff <= pos_sat;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               // Scale both magnitudes down together until the larger fits in 2^30.
               if (mx > 32'h4000_0000) begin
                  ux_ff <= ux_ff >> 1;
                  uy_ff <= uy_ff >> 1;
               end else if (mx == '0) begin
                  dir_x_ff     <= '0;
                  dir_y_ff     <= '0;
                  status_ff    <= ST_INTERP;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_UX_MUL;
               end
            end
            S_UX_MUL: begin
               sq_ff    <= prod[61:0];
               state_ff <= S_UY_MUL;
            end
            S_UY_MUL: begin
               sum_ff   <= sq_ff + prod[61:0];
               state_ff <= S_SQRT_GO;
            end
            S_SQRT_GO: begin
               sqrt_req_ff.start    <= 1'b1;
               sqrt_req_ff.radicand <= {2'b0, sum_ff};
               state_ff             <= S_SQRT;
            end
            S_SQRT: begin
               if (sqrt_rsp.done) begin
                  len_ff              <= sqrt_rsp.root;
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= {1'b0, ux_ff, 15'b0}
                                         + 48'(sqrt_rsp.root >> 1);
                  div_req_ff.divisor  <= sqrt_rsp.root;
                  state_ff            <= S_UX_DIV;
               end
            end
            S_UX_DIV: begin
               if (div_rsp.done) begin
                  dir_x_ff            <= ddx_ff[32] ? 16'(-unit_mag) : unit_mag;
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= {1'b0, uy_ff, 15'b0} + 48'(len_ff >> 1);
                  div_req_ff.divisor  <= len_ff;
                  state_ff            <= S_UY_DIV;
               end
            end
            S_UY_DIV: begin
               if (div_rsp.done) begin
                  dir_y_ff     <= ddy_ff[32] ? 16'(-unit_mag) : unit_mag;
                  status_ff    <= ST_INTERP;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end
            end
            S_PT_RD: state_ff <= S_PT_GOT;
            S_PT_GOT: begin
               pos_x_ff     <= rd_x;
               pos_y_ff     <= rd_y;
               dir_x_ff     <= '0;
               dir_y_ff     <= '0;
               status_ff    <= stat_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_ff;
   assign rsp_dir_x  = dir_x_ff;
   assign rsp_dir_y  = dir_y_ff;
   assign rsp_status = status_ff;

   // A response is only ever presented while no new request can enter.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("response valid while requests are accepted");

   // The search never reads past the points in use.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH_CMP |-> k_ff < n_ff && k_ff != '0)
      else $error("search index out of range");

   // A load answer carries no position or direction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STORED |->
         rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_dir_x == '0 && rsp_dir_y == '0)
      else $error("load response with nonzero payload");

   // The shared units are started only one at a time.
   assert property (@(posedge clock) disable iff (reset)
      !(div_req_ff.start && sqrt_req_ff.start))
      else $error("divider and square root started together");
endmodule
